/* src/mfqs_pkg.sv */
//------------------------------------------------------------------------------
// mfqs_pkg
// Shared constants, status codes and control structs of the feedback scheduler.
//------------------------------------------------------------------------------
`default_nettype none

package mfqs_pkg;

   localparam int MAX_PROCS = 64;
   localparam int LEVELS    = 5;

   localparam int PID_W     = 6;
   localparam int BURST_W   = 20;
   localparam int BQ_W      = 16;
   localparam int LVL_W     = 3;
   localparam int STATUS_W  = 3;
   localparam int SW_W      = 16;
   localparam int ELAPSED_W = 32;
   localparam int DONE_W    = 7;

   localparam int PTR_W     = $clog2(MAX_PROCS);
   localparam int OCC_W     = $clog2(MAX_PROCS + 1);
   localparam int LIDX_W    = $clog2(LEVELS);
   localparam int QNT_W     = BQ_W + LIDX_W;
   localparam int QDEPTH    = LEVELS * MAX_PROCS;
   localparam int QADDR_W   = $clog2(QDEPTH);
   localparam int PID_SLOTS = 1 << PID_W;

   localparam logic [BQ_W-1:0] BQ_RESET = 16'd200;

   localparam logic ACT_ARRIVE   = 1'b0;
   localparam logic ACT_DISPATCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_SLICE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FINISHED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 3'd4;

   typedef struct packed {
      logic              push_en;
      logic [LIDX_W-1:0] push_lvl;
      logic              pop_en;
      logic [LIDX_W-1:0] pop_lvl;
   } lvl_cmd_type;

   typedef struct packed {
      logic               any;
      logic [LIDX_W-1:0]  top_lvl;
      logic [QADDR_W-1:0] head_addr;
      logic [QADDR_W-1:0] push_addr;
      logic [LEVELS-1:0]  full;
      logic [LEVELS-1:0]  can_demote;
   } lvl_stat_type;

endpackage

`default_nettype wire

/* src/mfqs_req_if.sv */
//------------------------------------------------------------------------------
// mfqs_req_if
// Request channel: arrival or dispatch, with process id and burst time.
//------------------------------------------------------------------------------
`default_nettype none

interface mfqs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [mfqs_pkg::PID_W-1:0]    process_id;
   logic [mfqs_pkg::BURST_W-1:0]  burst_time;

   modport source (output valid, output action, output process_id, output burst_time,
                   input ready);
   modport sink   (input valid, input action, input process_id, input burst_time,
                   output ready);
endinterface

`default_nettype wire

/* src/mfqs_rsp_if.sv */
//------------------------------------------------------------------------------
// mfqs_rsp_if
// Result channel: one result per request.
//------------------------------------------------------------------------------
`default_nettype none

interface mfqs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mfqs_pkg::STATUS_W-1:0]  status;
   logic [mfqs_pkg::PID_W-1:0]     chosen_process;
   logic [mfqs_pkg::LVL_W-1:0]     level;
   logic [mfqs_pkg::BURST_W-1:0]   slice_time;
   logic [mfqs_pkg::BURST_W-1:0]   remaining_after;
   logic [mfqs_pkg::SW_W-1:0]      switches;
   logic [mfqs_pkg::ELAPSED_W-1:0] elapsed;
   logic [mfqs_pkg::DONE_W-1:0]    finished_count;

   modport source (output valid, output status, output chosen_process, output level,
                   output slice_time, output remaining_after, output switches,
                   output elapsed, output finished_count, input ready);
   modport sink   (input valid, input status, input chosen_process, input level,
                   input slice_time, input remaining_after, input switches,
                   input elapsed, input finished_count, output ready);
endinterface

`default_nettype wire

/* src/mfqs_csr_if.sv */
//------------------------------------------------------------------------------
// mfqs_csr_if
// Configuration write channel carrying the base quantum.
//------------------------------------------------------------------------------
`default_nettype none

interface mfqs_csr_if;
   logic                       valid;
   logic                       ready;
   logic [mfqs_pkg::BQ_W-1:0]  base_quantum;

   modport source (output valid, output base_quantum, input ready);
   modport sink   (input valid, input base_quantum, output ready);
endinterface

`default_nettype wire

/* src/multilevel_feedback_queue_scheduler.sv */
//------------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Five-level feedback scheduler with queue and remaining-time memories.
//------------------------------------------------------------------------------
// Usage:
//   req_if carries one request: an arrival (process id and burst time, queued
//   at the tail of level 0) or a dispatch (run the head of the highest busy
//   level for one slice). rsp_if returns exactly one result per request.
//   csr_if writes the level-0 quantum in ms; write it only while idle.
// Sequence:
//   an arrival or an idle dispatch loads the result register from FETCH, a
//   dispatch that finds a process from EXEC, once the output is free. The queue
//   memory read of the head id happens at acceptance, the remaining-time
//   memory read at that id follows, then the update and write back. req ready
//   returns with the same edge that loads the result. One request is in work
//   at a time.
// Reset:
//   synchronous; all levels empty, counters zero, quantum 200 ms. The memories
//   are not cleared, so there is no start-up pass.
// Stall:
//   the result sits in an output register; while it is not taken the next
//   request is still accepted and held once its result is ready.
//------------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_queue_scheduler (
   input  wire          clock,
   input  wire          reset,
   mfqs_req_if.sink     req_if,
   mfqs_rsp_if.source   rsp_if,
   mfqs_csr_if.sink     csr_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   state_type state_ff;

   logic                            act_ff;
   logic [mfqs_pkg::PID_W-1:0]      pid_ff;
   logic [mfqs_pkg::BURST_W-1:0]    burst_ff;
   logic [mfqs_pkg::LIDX_W-1:0]     sel_lvl_ff;
   logic                            found_ff;
   logic [mfqs_pkg::PID_W-1:0]      q_rdata_ff;
   logic [mfqs_pkg::BURST_W-1:0]    rem_rdata_ff;
   logic [mfqs_pkg::QNT_W-1:0]      quantum_ff;
   logic [mfqs_pkg::BQ_W-1:0]       base_quantum_ff;
   logic [mfqs_pkg::SW_W-1:0]       switch_ff;
   logic [mfqs_pkg::SW_W-1:0]       switch_in;
   logic [mfqs_pkg::ELAPSED_W-1:0]  elapsed_ff;
   logic [mfqs_pkg::ELAPSED_W-1:0]  elapsed_in;
   logic [mfqs_pkg::DONE_W-1:0]     done_ff;
   logic [mfqs_pkg::DONE_W-1:0]     done_in;

   logic                            rsp_valid_ff;
   logic [mfqs_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [mfqs_pkg::STATUS_W-1:0]   rsp_status_in;
   logic [mfqs_pkg::PID_W-1:0]      rsp_pid_ff;
   logic [mfqs_pkg::PID_W-1:0]      rsp_pid_in;
   logic [mfqs_pkg::LVL_W-1:0]      rsp_level_ff;
   logic [mfqs_pkg::LVL_W-1:0]      rsp_level_in;
   logic [mfqs_pkg::BURST_W-1:0]    rsp_slice_ff;
   logic [mfqs_pkg::BURST_W-1:0]    rsp_slice_in;
   logic [mfqs_pkg::BURST_W-1:0]    rsp_rem_ff;
   logic [mfqs_pkg::BURST_W-1:0]    rsp_rem_in;

   logic [mfqs_pkg::PID_W-1:0]      queue_mem [mfqs_pkg::QDEPTH];
   logic [mfqs_pkg::BURST_W-1:0]    rem_mem   [mfqs_pkg::PID_SLOTS];

   mfqs_pkg::lvl_cmd_type           lc_cmd;
   mfqs_pkg::lvl_stat_type          lc_stat;

   logic                            req_acc;
   logic                            out_free;
   logic                            rsp_load;
   logic                            rem_we;
   logic [mfqs_pkg::BURST_W-1:0]    rem_wdata;
   logic [mfqs_pkg::BURST_W-1:0]    quantum_ext;
   logic [mfqs_pkg::BURST_W-1:0]    slice;
   logic [mfqs_pkg::BURST_W-1:0]    rem_after;
   logic [mfqs_pkg::ELAPSED_W:0]    elapsed_sum;
   logic                            unfinished;

   mfqs_level_ctrl u_level_ctrl (
      .clock (clock),
      .reset (reset),
      .cmd   (lc_cmd),
      .stat  (lc_stat)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready = 1'b1;

   // slice arithmetic on the fetched remaining time
   assign quantum_ext = mfqs_pkg::BURST_W'(quantum_ff);
   assign slice       = (rem_rdata_ff < quantum_ext) ? rem_rdata_ff : quantum_ext;
   assign rem_after   = rem_rdata_ff - slice;
   assign unfinished  = (rem_after != '0);
   assign elapsed_sum = {1'b0, elapsed_ff} + (mfqs_pkg::ELAPSED_W + 1)'(slice);

   always_comb begin
      lc_cmd        = '0;
      rsp_load      = 1'b0;
      rem_we        = 1'b0;
      rem_wdata     = burst_ff;
      rsp_status_in = mfqs_pkg::STATUS_IDLE;
      rsp_pid_in    = '0;
      rsp_level_in  = '0;
      rsp_slice_in  = '0;
      rsp_rem_in    = '0;
      switch_in     = switch_ff;
      elapsed_in    = elapsed_ff;
      done_in       = done_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_FETCH: begin
            if (act_ff == mfqs_pkg::ACT_ARRIVE) begin
               rsp_load   = out_free;
               rsp_pid_in = pid_ff;
               if (lc_stat.full[0]) begin
                  rsp_status_in = mfqs_pkg::STATUS_DROPPED;
               end else begin
                  rsp_status_in   = mfqs_pkg::STATUS_ACCEPTED;
                  rsp_rem_in      = burst_ff;
                  lc_cmd.push_en  = out_free;
                  lc_cmd.push_lvl = '0;
                  rem_we          = out_free;
               end
            end else if (!found_ff) begin
               rsp_load = out_free;
            end
         end
         ST_EXEC: begin
            rsp_load     = out_free;
            rem_we       = out_free;
            rem_wdata    = rem_after;
            rsp_pid_in   = pid_ff;
            rsp_level_in = mfqs_pkg::LVL_W'(sel_lvl_ff);
            rsp_slice_in = slice;
            rsp_rem_in   = rem_after;
            elapsed_in   = elapsed_sum[mfqs_pkg::ELAPSED_W] ? '1
                         : elapsed_sum[mfqs_pkg::ELAPSED_W-1:0];
            if (unfinished) begin
               rsp_status_in = mfqs_pkg::STATUS_SLICE;
               if (switch_ff != '1) begin
                  switch_in = switch_ff + 1'b1;
               end
               // demote unless on the lowest level or the level below is full
               if (lc_stat.can_demote[sel_lvl_ff]) begin
                  lc_cmd.pop_en   = out_free;
                  lc_cmd.pop_lvl  = sel_lvl_ff;
                  lc_cmd.push_en  = out_free;
                  lc_cmd.push_lvl = sel_lvl_ff + 1'b1;
               end
            end else begin
               rsp_status_in  = mfqs_pkg::STATUS_FINISHED;
               lc_cmd.pop_en  = out_free;
               lc_cmd.pop_lvl = sel_lvl_ff;
               if (done_ff != '1) begin
                  done_in = done_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         switch_ff    <= '0;
         elapsed_ff   <= '0;
         done_ff      <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            switch_ff  <= switch_in;
            elapsed_ff <= elapsed_in;
            done_ff    <= done_in;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               if (act_ff == mfqs_pkg::ACT_DISPATCH && found_ff) begin
                  state_ff <= ST_EXEC;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pid_ff    <= rsp_pid_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_slice_ff  <= rsp_slice_in;
         rsp_rem_ff    <= rsp_rem_in;
      end
      if (req_acc) begin
         act_ff     <= req_if.action;
         pid_ff     <= req_if.process_id;
         burst_ff   <= req_if.burst_time;
         sel_lvl_ff <= lc_stat.top_lvl;
         found_ff   <= lc_stat.any;
      end
      if (state_ff == ST_FETCH && act_ff == mfqs_pkg::ACT_DISPATCH) begin
         pid_ff     <= q_rdata_ff;
         quantum_ff <= mfqs_pkg::QNT_W'({1'b0, sel_lvl_ff} + 1'b1)
                     * mfqs_pkg::QNT_W'(base_quantum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_quantum_ff <= mfqs_pkg::BQ_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         base_quantum_ff <= csr_if.base_quantum;
      end
   end

   // queue store: head of the busy level read while idle
   always_ff @(posedge clock) begin
      if (lc_cmd.push_en) begin
         queue_mem[lc_stat.push_addr] <= pid_ff;
      end
      if (state_ff == ST_IDLE) begin
         q_rdata_ff <= queue_mem[lc_stat.head_addr];
      end
   end

   // remaining time per id: read at the fetched head id
   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[pid_ff] <= rem_wdata;
      end
      if (state_ff == ST_FETCH) begin
         rem_rdata_ff <= rem_mem[q_rdata_ff];
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.chosen_process  = rsp_pid_ff;
   assign rsp_if.level           = rsp_level_ff;
   assign rsp_if.slice_time      = rsp_slice_ff;
   assign rsp_if.remaining_after = rsp_rem_ff;
   assign rsp_if.switches        = switch_ff;
   assign rsp_if.elapsed         = elapsed_ff;
   assign rsp_if.finished_count  = done_ff;

endmodule

`default_nettype wire

/* src/mfqs_level_ctrl.sv */
//------------------------------------------------------------------------------
// mfqs_level_ctrl
// Head, tail and occupancy of every level queue; finds the highest busy level.
//------------------------------------------------------------------------------
`default_nettype none

module mfqs_level_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  mfqs_pkg::lvl_cmd_type  cmd,
   output mfqs_pkg::lvl_stat_type stat
);

   logic [mfqs_pkg::PTR_W-1:0] head_ff [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::PTR_W-1:0] head_in [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::PTR_W-1:0] tail_ff [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::PTR_W-1:0] tail_in [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::OCC_W-1:0] occ_ff  [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::OCC_W-1:0] occ_in  [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::LEVELS-1:0] busy;

   function automatic logic [mfqs_pkg::PTR_W-1:0] wrap_inc(
      input logic [mfqs_pkg::PTR_W-1:0] ptr);
      wrap_inc = (ptr == mfqs_pkg::PTR_W'(mfqs_pkg::MAX_PROCS - 1)) ? '0 : ptr + 1'b1;
   endfunction

   function automatic logic [mfqs_pkg::QADDR_W-1:0] qaddr(
      input logic [mfqs_pkg::LIDX_W-1:0] lvl,
      input logic [mfqs_pkg::PTR_W-1:0]  ptr);
      qaddr = mfqs_pkg::QADDR_W'(lvl) * mfqs_pkg::QADDR_W'(mfqs_pkg::MAX_PROCS)
            + mfqs_pkg::QADDR_W'(ptr);
   endfunction

   always_comb begin
      logic push_hit;
      logic pop_hit;
      for (int k = 0; k < mfqs_pkg::LEVELS; k++) begin
         push_hit   = cmd.push_en && (cmd.push_lvl == mfqs_pkg::LIDX_W'(k));
         pop_hit    = cmd.pop_en && (cmd.pop_lvl == mfqs_pkg::LIDX_W'(k));
         head_in[k] = pop_hit ? wrap_inc(head_ff[k]) : head_ff[k];
         tail_in[k] = push_hit ? wrap_inc(tail_ff[k]) : tail_ff[k];
         occ_in[k]  = occ_ff[k] + mfqs_pkg::OCC_W'(push_hit) - mfqs_pkg::OCC_W'(pop_hit);
      end
   end

   always_comb begin
      stat.any        = 1'b0;
      stat.top_lvl    = '0;
      stat.can_demote = '0;
      for (int k = 0; k < mfqs_pkg::LEVELS; k++) begin
         busy[k]      = (occ_ff[k] != '0);
         stat.full[k] = (occ_ff[k] == mfqs_pkg::OCC_W'(mfqs_pkg::MAX_PROCS));
      end
      // lowest busy index wins
      for (int k = mfqs_pkg::LEVELS - 1; k >= 0; k--) begin
         if (busy[k]) begin
            stat.any     = 1'b1;
            stat.top_lvl = mfqs_pkg::LIDX_W'(k);
         end
      end
      for (int k = 0; k < mfqs_pkg::LEVELS - 1; k++) begin
         stat.can_demote[k] = !stat.full[k + 1];
      end
      stat.head_addr = qaddr(stat.top_lvl, head_ff[stat.top_lvl]);
      stat.push_addr = qaddr(cmd.push_lvl, tail_ff[cmd.push_lvl]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mfqs_pkg::LEVELS; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
            occ_ff[k]  <= '0;
         end
      end else begin
         for (int k = 0; k < mfqs_pkg::LEVELS; k++) begin
            head_ff[k] <= head_in[k];
            tail_ff[k] <= tail_in[k];
            occ_ff[k]  <= occ_in[k];
         end
      end
   end

endmodule

`default_nettype wire

/* src/mfqs_checker.sv */
//------------------------------------------------------------------------------
// mfqs_checker
// Port-level checks of the feedback scheduler, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module mfqs_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire [mfqs_pkg::STATUS_W-1:0]        rsp_status,
   input wire [mfqs_pkg::PID_W-1:0]           rsp_chosen_process,
   input wire [mfqs_pkg::BURST_W-1:0]         rsp_slice_time,
   input wire [mfqs_pkg::BURST_W-1:0]         rsp_remaining_after
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_remaining_after))
      else $error("stalled result changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mfqs_pkg::STATUS_IDLE |->
         rsp_chosen_process == '0 && rsp_slice_time == '0 && rsp_remaining_after == '0)
      else $error("idle result carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mfqs_pkg::STATUS_FINISHED |-> rsp_remaining_after == '0)
      else $error("finished process has time left");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mfqs_pkg::STATUS_SLICE |-> rsp_remaining_after != '0)
      else $error("slice result with no time left");

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker u_mfqs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_status          (rsp_if.status),
   .rsp_chosen_process  (rsp_if.chosen_process),
   .rsp_slice_time      (rsp_if.slice_time),
   .rsp_remaining_after (rsp_if.remaining_after)
);

`default_nettype wire

/* verif/multilevel_feedback_queue_scheduler_test.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_test
// Self-checking bench for the five-level feedback scheduler. A directed table
// walks idle dispatch, arrivals at the field extremes, duplicate ids, zero
// bursts, demotion down to the lowest level and exact-quantum slices. Random
// phases then sweep the base quantum (zero, one, maximum and others), fill
// level 0 until arrivals are dropped, and block demotion into a full level.
// One phase holds the result side off for a long stretch. Every result is
// checked against its row's expected values or an in-bench scheduler model.
//------------------------------------------------------------------------------

module multilevel_feedback_queue_scheduler_test;

   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [mfqs_pkg::STATUS_W-1:0]  status;
      logic [mfqs_pkg::PID_W-1:0]     pid;
      logic [mfqs_pkg::LVL_W-1:0]     level;
      logic [mfqs_pkg::BURST_W-1:0]   slice;
      logic [mfqs_pkg::BURST_W-1:0]   left;
      logic [mfqs_pkg::SW_W-1:0]      switches;
      logic [mfqs_pkg::ELAPSED_W-1:0] elapsed;
      logic [mfqs_pkg::DONE_W-1:0]    done;
   } sched_result_type;

   typedef struct packed {
      logic                         act;
      logic [mfqs_pkg::PID_W-1:0]   pid;
      logic [mfqs_pkg::BURST_W-1:0] burst;
      logic                         typed;
      sched_result_type             want;
   } plan_row_type;

   typedef struct packed {
      logic                      rand_q;
      logic [mfqs_pkg::BQ_W-1:0] quantum;
      int unsigned               count;
      int unsigned               arrive_pct;
      logic                      nonzero;
      logic                      idle;
      logic                      squeeze;
   } phase_type;

   // quantum is 200 ms out of reset
   localparam plan_row_type DIRECTED [25] = '{
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b1,
        '{mfqs_pkg::STATUS_IDLE, 6'd0, 3'd0, 20'd0, 20'd0, 16'd0, 32'd0, 7'd0}},
      '{mfqs_pkg::ACT_ARRIVE, 6'd0, 20'd0, 1'b1,
        '{mfqs_pkg::STATUS_ACCEPTED, 6'd0, 3'd0, 20'd0, 20'd0, 16'd0, 32'd0, 7'd0}},
      '{mfqs_pkg::ACT_ARRIVE, 6'd63, 20'hFFFFF, 1'b1,
        '{mfqs_pkg::STATUS_ACCEPTED, 6'd63, 3'd0, 20'd0, 20'hFFFFF, 16'd0, 32'd0, 7'd0}},
      '{mfqs_pkg::ACT_ARRIVE, 6'd5, 20'd350, 1'b1,
        '{mfqs_pkg::STATUS_ACCEPTED, 6'd5, 3'd0, 20'd0, 20'd350, 16'd0, 32'd0, 7'd0}},
      // same id again: overwrites the remaining time of both entries
      '{mfqs_pkg::ACT_ARRIVE, 6'd5, 20'd100, 1'b1,
        '{mfqs_pkg::STATUS_ACCEPTED, 6'd5, 3'd0, 20'd0, 20'd100, 16'd0, 32'd0, 7'd0}},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b1,
        '{mfqs_pkg::STATUS_FINISHED, 6'd0, 3'd0, 20'd0, 20'd0, 16'd0, 32'd0, 7'd1}},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b1,
        '{mfqs_pkg::STATUS_SLICE, 6'd63, 3'd0, 20'd200, 20'd1048375, 16'd1, 32'd200,
          7'd1}},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_ARRIVE, 6'd42, 20'd1, 1'b0, '0},
      '{mfqs_pkg::ACT_ARRIVE, 6'd21, 20'd200, 1'b0, '0},
      '{mfqs_pkg::ACT_ARRIVE, 6'd1, 20'd201, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      // lowest level: process stays at the head
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_ARRIVE, 6'd42, 20'h55555, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_ARRIVE, 6'd63, 20'd0, 1'b0, '0},
      '{mfqs_pkg::ACT_DISPATCH, 6'd0, 20'd0, 1'b0, '0}
   };

   localparam phase_type PHASES [10] = '{
      '{1'b0, 16'd0, 70, 100, 1'b1, 1'b1, 1'b0},    // fill level 0 until drops
      '{1'b0, 16'd0, 64, 0, 1'b1, 1'b0, 1'b0},      // push all down to level 1
      '{1'b0, 16'd0, 70, 100, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'd0, 20, 0, 1'b1, 1'b1, 1'b0},      // level 1 full, no demotion
      '{1'b0, 16'd1, 200, 50, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'd65535, 400, 30, 1'b0, 1'b1, 1'b0},
      '{1'b0, 16'd200, 300, 50, 1'b0, 1'b1, 1'b0},
      '{1'b1, 16'd0, 300, 50, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'd150, 200, 70, 1'b0, 1'b0, 1'b1},
      '{1'b0, 16'd65535, 250, 10, 1'b0, 1'b1, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   mfqs_req_if req_if();
   mfqs_rsp_if rsp_if();
   mfqs_csr_if csr_if();

   multilevel_feedback_queue_scheduler uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #2 clock = ~clock;

   // scheduler model state
   logic [mfqs_pkg::PID_W-1:0]     lvl_fifo [mfqs_pkg::LEVELS][mfqs_pkg::MAX_PROCS];
   int unsigned                    lvl_head [mfqs_pkg::LEVELS];
   int unsigned                    lvl_count [mfqs_pkg::LEVELS];
   logic [mfqs_pkg::BURST_W-1:0]   time_left [mfqs_pkg::PID_SLOTS];
   logic [mfqs_pkg::SW_W-1:0]      switch_cnt;
   logic [mfqs_pkg::ELAPSED_W-1:0] busy_ms;
   logic [mfqs_pkg::DONE_W-1:0]    done_cnt;
   logic [mfqs_pkg::BQ_W-1:0]      quantum_ms;

   sched_result_type pending_results [$];
   int unsigned      fail_count = 0;
   int unsigned      result_count = 0;
   int unsigned      cycle_count = 0;
   logic             idle_on = 1'b1;
   logic             rsp_hold_pending = 1'b0;

   function automatic void enqueue(input int unsigned lvl,
                                   input logic [mfqs_pkg::PID_W-1:0] pid);
      lvl_fifo[lvl][(lvl_head[lvl] + lvl_count[lvl]) % mfqs_pkg::MAX_PROCS] = pid;
      lvl_count[lvl]++;
   endfunction

   function automatic sched_result_type schedule_step(
      input logic act,
      input logic [mfqs_pkg::PID_W-1:0] pid,
      input logic [mfqs_pkg::BURST_W-1:0] burst);
      sched_result_type             r;
      int                           top;
      int unsigned                  grant;
      logic [mfqs_pkg::PID_W-1:0]   cur;
      logic [mfqs_pkg::BURST_W-1:0] left;
      logic [mfqs_pkg::BURST_W-1:0] slice;
      logic [mfqs_pkg::ELAPSED_W:0] sum;
      r = '0;
      if (act == mfqs_pkg::ACT_ARRIVE) begin
         r.pid = pid;
         if (lvl_count[0] >= mfqs_pkg::MAX_PROCS) begin
            r.status = mfqs_pkg::STATUS_DROPPED;
         end else begin
            time_left[pid] = burst;
            enqueue(0, pid);
            r.status = mfqs_pkg::STATUS_ACCEPTED;
            r.left = burst;
         end
      end else begin
         top = mfqs_pkg::LEVELS;
         for (int l = mfqs_pkg::LEVELS - 1; l >= 0; l--)
            if (lvl_count[l] != 0) top = l;
         if (top == mfqs_pkg::LEVELS) begin
            r.status = mfqs_pkg::STATUS_IDLE;
         end else begin
            cur = lvl_fifo[top][lvl_head[top]];
            grant = (top + 1) * quantum_ms;
            left = time_left[cur];
            slice = (left < grant) ? left : grant[mfqs_pkg::BURST_W-1:0];
            left = left - slice;
            time_left[cur] = left;
            sum = {1'b0, busy_ms} + (mfqs_pkg::ELAPSED_W + 1)'(slice);
            busy_ms = sum[mfqs_pkg::ELAPSED_W] ? '1 : sum[mfqs_pkg::ELAPSED_W-1:0];
            if (left != 0) begin
               if (switch_cnt != '1) switch_cnt++;
               // demote unless already lowest or the next level is full
               if (top + 1 < mfqs_pkg::LEVELS && lvl_count[top + 1] < mfqs_pkg::MAX_PROCS)
               begin
                  lvl_head[top] = (lvl_head[top] + 1) % mfqs_pkg::MAX_PROCS;
                  lvl_count[top]--;
                  enqueue(top + 1, cur);
               end
               r.status = mfqs_pkg::STATUS_SLICE;
            end else begin
               lvl_head[top] = (lvl_head[top] + 1) % mfqs_pkg::MAX_PROCS;
               lvl_count[top]--;
               if (done_cnt != '1) done_cnt++;
               r.status = mfqs_pkg::STATUS_FINISHED;
            end
            r.pid = cur;
            r.level = top[mfqs_pkg::LVL_W-1:0];
            r.slice = slice;
            r.left = left;
         end
      end
      r.switches = switch_cnt;
      r.elapsed = busy_ms;
      r.done = done_cnt;
      return r;
   endfunction

   function automatic string show_result(input sched_result_type r);
      return $sformatf("st=%0d pid=%0d lvl=%0d slice=%0d rem=%0d sw=%0d el=%0d done=%0d",
                       r.status, r.pid, r.level, r.slice, r.left, r.switches,
                       r.elapsed, r.done);
   endfunction

   function automatic logic [mfqs_pkg::BURST_W-1:0] draw_burst(input logic nonzero);
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0 && !nonzero) return '0;
      if (pick == 1) return '1;
      if (pick < 6)
         return mfqs_pkg::BURST_W'($urandom_range(1, (1 << mfqs_pkg::BURST_W) - 1));
      return mfqs_pkg::BURST_W'($urandom_range(1, 4000));
   endfunction

   // offer one request; valid only drops when a gap is drawn
   task automatic offer_request(input logic act, input logic [mfqs_pkg::PID_W-1:0] pid,
                                input logic [mfqs_pkg::BURST_W-1:0] burst,
                                input logic typed, input sched_result_type want);
      int unsigned      gap;
      sched_result_type got;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.process_id <= pid;
      req_if.burst_time <= burst;
      do @(posedge clock); while (!req_if.ready);
      got = schedule_step(act, pid, burst);
      pending_results.push_back(typed ? want : got);
   endtask

   task automatic write_quantum(input logic [mfqs_pkg::BQ_W-1:0] q);
      csr_if.valid        <= 1'b1;
      csr_if.base_quantum <= q;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      quantum_ms = q;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.status, rsp_if.chosen_process, rsp_if.level, rsp_if.slice_time,
                 rsp_if.remaining_after, rsp_if.switches, rsp_if.elapsed,
                 rsp_if.finished_count};
         if (pending_results.size() == 0) begin
            if (fail_count < 10)
               $display("result %0d with no request pending: %s", result_count,
                        show_result(got));
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.pid !== want.pid ||
                got.level !== want.level || got.slice !== want.slice ||
                got.left !== want.left || got.switches !== want.switches ||
                got.elapsed !== want.elapsed || got.done !== want.done) begin
               if (fail_count < 10) begin
                  $display("result %0d mismatch", result_count);
                  $display("  expected %s", show_result(want));
                  $display("  actual   %s", show_result(got));
               end
               fail_count++;
            end
         end
         result_count++;
      end
   end

   // result side: random gaps, plus one long hold-off on request
   initial begin : result_sink
      int unsigned gap;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_pending) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_pending = 1'b0;
         end
         gap = idle_on ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin : stimulus
      logic                      act;
      logic [mfqs_pkg::BQ_W-1:0] q;
      req_if.valid        <= 1'b0;
      req_if.action       <= mfqs_pkg::ACT_ARRIVE;
      req_if.process_id   <= '0;
      req_if.burst_time   <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.base_quantum <= '0;
      foreach (lvl_head[l]) begin
         lvl_head[l] = 0;
         lvl_count[l] = 0;
      end
      foreach (time_left[p]) time_left[p] = '0;
      switch_cnt = '0;
      busy_ms = '0;
      done_cnt = '0;
      quantum_ms = mfqs_pkg::BQ_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         offer_request(DIRECTED[i].act, DIRECTED[i].pid, DIRECTED[i].burst,
                       DIRECTED[i].typed, DIRECTED[i].want);
      req_if.valid <= 1'b0;

      foreach (PHASES[k]) begin
         // quantum only changes once every request has its result
         while (pending_results.size() != 0) @(posedge clock);
         q = PHASES[k].rand_q ? mfqs_pkg::BQ_W'($urandom_range(2, 65534))
                              : PHASES[k].quantum;
         write_quantum(q);
         idle_on = PHASES[k].idle;
         if (PHASES[k].squeeze) rsp_hold_pending = 1'b1;
         repeat (PHASES[k].count) begin
            act = ($urandom_range(0, 99) < PHASES[k].arrive_pct) ? mfqs_pkg::ACT_ARRIVE
                                                                 : mfqs_pkg::ACT_DISPATCH;
            offer_request(act, mfqs_pkg::PID_W'($urandom_range(0, 63)),
                          draw_burst(PHASES[k].nonzero), 1'b0, '0);
         end
         req_if.valid <= 1'b0;
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += pending_results.size();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* multilevel_feedback_queue_scheduler.f */
src/mfqs_pkg.sv
src/mfqs_req_if.sv
src/mfqs_rsp_if.sv
src/mfqs_csr_if.sv
src/mfqs_level_ctrl.sv
src/multilevel_feedback_queue_scheduler.sv
src/mfqs_checker.sv
verif/multilevel_feedback_queue_scheduler_test.sv
